@@ rtl/quadrature_encoder_accel_macros.svh @@
// Assertion macros shared by the encoder checker.
// No dependencies; include by bare file name.
`ifndef QUADRATURE_ENCODER_ACCEL_MACROS_SVH
`define QUADRATURE_ENCODER_ACCEL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QEA_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("encoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QEA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("encoder check failed");

`endif

@@ rtl/qea_pkg.sv @@
// Types, register indexes, reset values and the direction table of the encoder decoder.
// No dependencies.
package qea_pkg;

	typedef struct packed {
		logic        pin_a;
		logic        pin_b;
		logic [31:0] now_us;
		logic [31:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic signed [6:0]  step;
		logic signed [31:0] position;
	} result_t;

	typedef struct packed {
		logic [19:0] poll_interval_us;
		logic [19:0] reversal_hold_us;
		logic [6:0]  accumulation_threshold;
		logic [7:0]  stable_polls;
		logic [15:0] accel_timeout_ms;
		logic [5:0]  max_accel;
		logic [1:0]  initial_levels;
	} cfg_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_HOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACC_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_POLLS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TIMEOUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVELS   = 3'd6;

	localparam logic [19:0] POLL_INTERVAL_RST = 20'd5000;
	localparam logic [19:0] REVERSAL_HOLD_RST = 20'd50000;
	localparam logic [6:0]  ACC_THRESHOLD_RST = 7'd2;
	localparam logic [7:0]  STABLE_POLLS_RST  = 8'd3;
	localparam logic [15:0] ACCEL_TIMEOUT_RST = 16'd400;
	localparam logic [5:0]  MAX_ACCEL_RST     = 6'd30;
	localparam logic [1:0]  INIT_LEVELS_RST   = 2'd3;

	localparam int US_CFG_W = 20;

	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	localparam logic signed [7:0] ACC_LIMIT = 8'sd127;
	localparam logic [7:0]        QUIET_MAX = 8'd255;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_PW    = 2;

endpackage

@@ rtl/qea_front.sv @@
// Front part: poll filter, transition decode, accumulation and evaluation.
// Depends on qea_pkg; pushes step events to the event queue.
module qea_front #(
	parameter int TW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  qea_pkg::sample_t  sample,
	input  qea_pkg::cfg_t     cfg,
	input  logic              levels_load,
	input  logic [1:0]        levels_value,
	output logic              ev_push,
	output logic [TW:0]       ev_data
);
	import qea_pkg::*;

	localparam int CW = (TW > US_CFG_W) ? TW : US_CFG_W;

	logic [1:0]        prev_levels_q;
	logic [TW-1:0]     last_poll_q;
	logic [TW-1:0]     last_tr_q;
	logic signed [1:0] dir_q;
	logic signed [7:0] acc_q;
	logic [7:0]        quiet_q;

	logic [1:0]        levels;
	logic [TW-1:0]     now_us;
	logic [TW-1:0]     now_ms;
	logic [TW-1:0]     dt_poll;
	logic [TW-1:0]     dt_tr;
	logic              poll_ok;
	logic              rev_ok;
	logic signed [1:0] change;
	logic signed [8:0] acc_sum;
	logic signed [7:0] acc_sat;
	logic signed [7:0] acc_n;
	logic signed [1:0] dir_n;
	logic [TW-1:0]     tr_n;
	logic [7:0]        quiet_base;
	logic [7:0]        quiet_inc;
	logic [7:0]        acc_u;
	logic [7:0]        mag;
	logic              evaluate;
	logic              emit;
	logic              take;

	assign levels  = {sample.pin_a, sample.pin_b};
	assign now_us  = TW'(sample.now_us);
	assign now_ms  = TW'(sample.now_ms);
	assign dt_poll = now_us - last_poll_q;
	assign dt_tr   = now_us - last_tr_q;
	assign poll_ok = CW'(dt_poll) >= CW'(cfg.poll_interval_us);
	assign rev_ok  = CW'(dt_tr) > CW'(cfg.reversal_hold_us);
	assign change  = DIR_TABLE[{prev_levels_q, levels}];
	assign acc_sum = 9'(acc_q) + 9'(change);

	always_comb begin
		if (acc_sum > 9'(ACC_LIMIT))
			acc_sat = ACC_LIMIT;
		else if (acc_sum < -9'(ACC_LIMIT))
			acc_sat = -ACC_LIMIT;
		else
			acc_sat = acc_sum[7:0];
	end

	always_comb begin
		acc_n      = acc_q;
		dir_n      = dir_q;
		tr_n       = last_tr_q;
		quiet_base = quiet_q;
		if (levels != prev_levels_q && change != DIR_NONE) begin
			if (dir_q == DIR_NONE || dir_q == change) begin
				acc_n      = acc_sat;
				dir_n      = change;
				tr_n       = now_us;
				quiet_base = '0;
			end else if (rev_ok) begin
				// reversal after enough quiet time: restart the run
				acc_n      = 8'(change);
				dir_n      = change;
				tr_n       = now_us;
				quiet_base = '0;
			end
		end
		quiet_inc = (quiet_base == QUIET_MAX) ? quiet_base : quiet_base + 8'd1;
		acc_u     = acc_n;
		mag       = acc_n[7] ? (~acc_u + 8'd1) : acc_u;
		evaluate  = (quiet_inc >= cfg.stable_polls) && (acc_n != 8'sd0);
		emit      = evaluate && (mag >= {1'b0, cfg.accumulation_threshold});
	end

	assign take    = accept && poll_ok;
	assign ev_push = take && emit;
	assign ev_data = {acc_n[7], now_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= INIT_LEVELS_RST;
			last_poll_q   <= '0;
			last_tr_q     <= '0;
			dir_q         <= DIR_NONE;
			acc_q         <= '0;
			quiet_q       <= '0;
		end else if (levels_load) begin
			prev_levels_q <= levels_value;
		end else if (take) begin
			prev_levels_q <= levels;
			last_poll_q   <= now_us;
			last_tr_q     <= tr_n;
			if (evaluate) begin
				acc_q   <= '0;
				dir_q   <= DIR_NONE;
				quiet_q <= '0;
			end else begin
				acc_q   <= acc_n;
				dir_q   <= dir_n;
				quiet_q <= quiet_inc;
			end
		end
	end

endmodule

@@ rtl/qea_evq.sv @@
// Short event queue between the front and back parts.
// Depends on qea_pkg for the depth.
module qea_evq #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         nonempty
);
	import qea_pkg::*;

	logic [W-1:0]      entry_q [EVQ_DEPTH];
	logic [EVQ_PW-1:0] wr_ptr_q;
	logic [EVQ_PW-1:0] rd_ptr_q;
	logic [EVQ_PW:0]   cnt_q;

	assign full     = cnt_q == (EVQ_PW+1)'(EVQ_DEPTH);
	assign nonempty = cnt_q != '0;
	assign dout     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/qea_back.sv @@
// Back part: run-length acceleration, detent position and the result register.
// Depends on qea_pkg; pops step events from the event queue.
module qea_back #(
	parameter int TW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	input  logic [TW:0]       ev_data,
	output logic              ev_pop,
	input  qea_pkg::cfg_t     cfg,
	output logic              empty,
	input  logic              pop,
	output qea_pkg::result_t  result
);
	import qea_pkg::*;

	logic [5:0]    run_q;
	logic [TW-1:0] last_step_q;
	logic [31:0]   pos_q;
	logic          out_valid_q;
	result_t       result_q;

	logic          neg;
	logic [TW-1:0] ev_ms;
	logic [TW-1:0] dms;
	logic [5:0]    cap;
	logic [6:0]    run_inc;
	logic [5:0]    run_n;
	logic [6:0]    step_mag;
	logic [31:0]   pos_n;

	assign neg     = ev_data[TW];
	assign ev_ms   = ev_data[TW-1:0];
	assign dms     = ev_ms - last_step_q;
	assign cap     = (cfg.max_accel == '0) ? 6'd1 : cfg.max_accel;
	assign run_inc = {1'b0, run_q} + 7'd1;

	always_comb begin
		if (dms < TW'(cfg.accel_timeout_ms))
			run_n = (run_inc > {1'b0, cap}) ? cap : run_inc[5:0];
		else
			run_n = 6'd1;
	end

	assign step_mag = {1'b0, run_n};
	assign pos_n    = neg ? pos_q - 32'd1 : pos_q + 32'd1;

	// advance when the result slot is free or being drained this cycle
	assign ev_pop = ev_valid && (!out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			result_q.step     <= neg ? (~step_mag + 7'd1) : step_mag;
			result_q.position <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			last_step_q <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_pop) begin
				run_q       <= run_n;
				last_step_q <= ev_ms;
				pos_q       <= pos_n;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/quadrature_encoder_accel.sv @@
// Path: a poll that yields a step is written into the event queue, then into the result
// register that drives the result ports; a busy result register holds it in the queue.
// Throughput: one poll per cycle while the event queue is not full; a 4-entry event queue
// plus the result register absorb stalls on the result side.
// Reset: arst_n low clears all state but the queue and result data asynchronously and loads
// register defaults; there is no clearing pass, so polls are accepted right after reset.
module quadrature_encoder_accel #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  qea_pkg::sample_t                   sample,
	output logic                               empty,
	input  logic                               pop,
	output qea_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qea_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_data
);
	import qea_pkg::*;

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic              levels_load;
	logic              accept;
	logic              ev_push;
	logic [TIME_WIDTH:0] ev_wdata;
	logic [TIME_WIDTH:0] ev_rdata;
	logic              ev_nonempty;
	logic              ev_pop;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign levels_load = cfg_wr && (cfg_index == REG_INIT_LEVELS);
	assign accept      = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_interval_us       <= POLL_INTERVAL_RST;
			cfg_q.reversal_hold_us       <= REVERSAL_HOLD_RST;
			cfg_q.accumulation_threshold <= ACC_THRESHOLD_RST;
			cfg_q.stable_polls           <= STABLE_POLLS_RST;
			cfg_q.accel_timeout_ms       <= ACCEL_TIMEOUT_RST;
			cfg_q.max_accel              <= MAX_ACCEL_RST;
			cfg_q.initial_levels         <= INIT_LEVELS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_POLL_INTERVAL: cfg_q.poll_interval_us       <= cfg_data[19:0];
				REG_REVERSAL_HOLD: cfg_q.reversal_hold_us       <= cfg_data[19:0];
				REG_ACC_THRESHOLD: cfg_q.accumulation_threshold <= cfg_data[6:0];
				REG_STABLE_POLLS:  cfg_q.stable_polls           <= cfg_data[7:0];
				REG_ACCEL_TIMEOUT: cfg_q.accel_timeout_ms       <= cfg_data[15:0];
				REG_MAX_ACCEL:     cfg_q.max_accel              <= cfg_data[5:0];
				REG_INIT_LEVELS:   cfg_q.initial_levels         <= cfg_data[1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	qea_front #(
		.TW (TIME_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample       (sample),
		.cfg          (cfg_q),
		.levels_load  (levels_load),
		.levels_value (cfg_data[1:0]),
		.ev_push      (ev_push),
		.ev_data      (ev_wdata)
	);

	qea_evq #(
		.W (TIME_WIDTH + 1)
	) u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_push),
		.din      (ev_wdata),
		.full     (full),
		.pop      (ev_pop),
		.dout     (ev_rdata),
		.nonempty (ev_nonempty)
	);

	qea_back #(
		.TW (TIME_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_nonempty),
		.ev_data  (ev_rdata),
		.ev_pop   (ev_pop),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

@@ rtl/qea_checker.sv @@
// Port-level checks of the encoder decoder, bound to the top level.
// Depends on qea_pkg and quadrature_encoder_accel_macros.svh.
`include "quadrature_encoder_accel_macros.svh"

module qea_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input qea_pkg::sample_t              sample,
	input logic                          empty,
	input logic                          pop,
	input qea_pkg::result_t              result,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [qea_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);
	import qea_pkg::*;

	logic        step_ok;
	logic        taken;
	logic [31:0] pos;

	assign step_ok = (result.step != 7'sd0) && (result.step != 7'sb100_0000);
	assign taken   = pop && !empty;
	assign pos     = result.position;

	// a shown step is never zero and never the most negative step value
	`QEA_ASSERT_NOW(a_step_range, clk, arst_n, !empty, step_ok)

	// consecutive steps always move the detent position
	`QEA_ASSERT_NOW(a_pos_moves, clk, arst_n, taken ##1 !empty, pos != $past(pos))

	// configuration writes are never stalled
	`QEA_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// a waiting result holds until its transfer
	`QEA_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty)
	`QEA_ASSERT_NEXT(a_result_stable, clk, arst_n, !empty && !pop, $stable(result))

endmodule

bind quadrature_encoder_accel qea_checker u_qea_checker (.*);

@@ verif/quadrature_encoder_accel_test.sv @@
// Self-checking test for the quadrature encoder decoder: drives encoder polls and
// register writes, predicts detent steps in a scoreboard and checks each popped result.
// Depends on qea_pkg and quadrature_encoder_accel.
module quadrature_encoder_accel_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qea_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;

	typedef enum int {PACE_STEADY, PACE_EARLY, PACE_HOLD} pace_t;

	// Tracks the decoder state and keeps the detent steps still owed by the block.
	class detent_tracker;
		cfg_t        regs;
		logic [1:0]  prev_levels;
		logic [31:0] last_poll_us;
		logic [31:0] last_move_us;
		logic [31:0] last_step_ms;
		logic [31:0] position;
		int          move_dir;
		int          acc;
		int          quiet;
		int          run_len;
		result_t     expected_steps[$];
		int          polls_taken;
		int          failures;

		function new();
			regs.poll_interval_us = POLL_INTERVAL_RST;
			regs.reversal_hold_us = REVERSAL_HOLD_RST;
			regs.accumulation_threshold = ACC_THRESHOLD_RST;
			regs.stable_polls = STABLE_POLLS_RST;
			regs.accel_timeout_ms = ACCEL_TIMEOUT_RST;
			regs.max_accel = MAX_ACCEL_RST;
			regs.initial_levels = INIT_LEVELS_RST;
			prev_levels = INIT_LEVELS_RST;
			last_poll_us = '0;
			last_move_us = '0;
			last_step_ms = '0;
			position = '0;
			move_dir = 0;
			acc = 0;
			quiet = 0;
			run_len = 0;
			polls_taken = 0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_POLL_INTERVAL: regs.poll_interval_us = data[19:0];
				REG_REVERSAL_HOLD: regs.reversal_hold_us = data[19:0];
				REG_ACC_THRESHOLD: regs.accumulation_threshold = data[6:0];
				REG_STABLE_POLLS:  regs.stable_polls = data[7:0];
				REG_ACCEL_TIMEOUT: regs.accel_timeout_ms = data[15:0];
				REG_MAX_ACCEL:     regs.max_accel = data[5:0];
				REG_INIT_LEVELS: begin
					regs.initial_levels = data[1:0];
					prev_levels = data[1:0];
				end
				default: ;
			endcase
		endfunction

		function void take_poll(sample_t poll);
			logic [1:0] lv;
			logic [1:0] turn;
			int         change;
			int         mag;
			int         cap;
			result_t    r;
			lv = {poll.pin_a, poll.pin_b};
			if (poll.now_us - last_poll_us < 32'(regs.poll_interval_us))
				return;
			last_poll_us = poll.now_us;
			polls_taken++;
			if (lv != prev_levels) begin
				// quadrature phase 0..3 from Gray levels, one quarter turn is +-1
				turn = {lv[0], ^lv} - {prev_levels[0], ^prev_levels};
				change = turn == 2'd1 ? 1 : turn == 2'd3 ? -1 : 0;
				if (change != 0) begin
					if (move_dir == 0 || move_dir == change) begin
						acc += change;
						if (acc > 127) acc = 127;
						if (acc < -127) acc = -127;
						move_dir = change;
						last_move_us = poll.now_us;
						quiet = 0;
					end else if (poll.now_us - last_move_us > 32'(regs.reversal_hold_us)) begin
						acc = change;
						move_dir = change;
						last_move_us = poll.now_us;
						quiet = 0;
					end
				end
				prev_levels = lv;
			end
			if (quiet < 255)
				quiet++;
			if (quiet >= int'(regs.stable_polls) && acc != 0) begin
				mag = acc < 0 ? -acc : acc;
				if (mag >= int'(regs.accumulation_threshold)) begin
					cap = regs.max_accel == 0 ? 1 : int'(regs.max_accel);
					position += acc > 0 ? 32'd1 : 32'hFFFF_FFFF;
					if (poll.now_ms - last_step_ms < 32'(regs.accel_timeout_ms))
						run_len = run_len + 1 > cap ? cap : run_len + 1;
					else
						run_len = 1;
					last_step_ms = poll.now_ms;
					r.step = acc > 0 ? 7'(run_len) : 7'(-run_len);
					r.position = position;
					expected_steps.push_back(r);
				end
				acc = 0;
				move_dir = 0;
				quiet = 0;
			end
		endfunction

		function void check_step(result_t got);
			result_t want;
			if (expected_steps.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected step %0d position %0d", got.step, got.position);
				return;
			end
			want = expected_steps.pop_front();
			if (got.step !== want.step || got.position !== want.position) begin
				failures++;
				if (failures <= 10)
					$display("step mismatch: expected step %0d position %0d, got step %0d position %0d",
						want.step, want.position, got.step, got.position);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	sample_t              poll_in;
	logic                 empty;
	logic                 pop;
	result_t              step_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	detent_tracker tracker;

	logic [1:0]  levels;
	logic [31:0] now_us;
	logic [31:0] now_ms;
	int          burst_left;
	logic        rx_hold_req;

	logic [15:0] rx_pattern;
	int          rx_tick;
	int          hold_left;
	logic        hold_seen;
	int          stall_cycles;

	quadrature_encoder_accel i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (poll_in),
		.empty     (empty),
		.pop       (pop),
		.result    (step_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: check every transfer, stall on a rotating pattern, honor hold-off requests.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				tracker.check_step(step_out);
			if (rx_hold_req && !hold_seen)
				hold_left = HOLD_OFF_CYCLES;
			hold_seen = rx_hold_req;
			if (rx_tick == 0) begin
				rx_tick = 64;
				case ($urandom_range(0, 3))
					0: rx_pattern = 16'hFFFF;
					1: rx_pattern = 16'($urandom);
					2: rx_pattern = 16'($urandom | $urandom);
					default: rx_pattern = 16'($urandom & $urandom);
				endcase
			end
			rx_tick--;
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= rx_pattern[0];
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_poll(input logic [1:0] lv, input logic [31:0] us, input logic [31:0] ms);
		sample_t poll;
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		poll.pin_a = lv[1];
		poll.pin_b = lv[0];
		poll.now_us = us;
		poll.now_ms = ms;
		push <= 1'b1;
		poll_in <= poll;
		do @(posedge clk); while (full);
		tracker.take_poll(poll);
		burst_left--;
	endtask

	task automatic next_poll(input logic [1:0] lv, input pace_t pace);
		logic [31:0] gap_us;
		logic [31:0] gap_ms;
		logic [31:0] span;
		span = 32'(tracker.regs.poll_interval_us);
		case (pace)
			PACE_EARLY: gap_us = span == 0 ? 32'd0 : $urandom_range(0, span - 1);
			PACE_HOLD: begin
				// land just below, on or just past the reversal hold
				gap_us = 32'(tracker.regs.reversal_hold_us) + $urandom_range(0, 2);
				gap_us = gap_us == 0 ? 32'd0 : gap_us - 1;
				if (gap_us < span)
					gap_us = span;
			end
			default: gap_us = $urandom_range(0, 15) == 0 ? span : span + $urandom_range(0, span / 8 + 2);
		endcase
		case ($urandom_range(0, 11))
			0: gap_ms = $urandom;
			1: gap_ms = 32'(tracker.regs.accel_timeout_ms) + $urandom_range(0, 1);
			default: gap_ms = $urandom_range(0, tracker.regs.accel_timeout_ms / 8 + 1);
		endcase
		now_us += gap_us;
		now_ms += gap_ms;
		send_poll(lv, now_us, now_ms);
	endtask

	task automatic turn(input int dir, input pace_t pace);
		logic [1:0] ph;
		ph = {levels[0], ^levels} + 2'(dir);
		levels = {^ph, ph[1]};
		next_poll(levels, pace);
	endtask

	task automatic run_episodes(input int quota);
		int target;
		int dir;
		int n;
		int kind;
		target = tracker.polls_taken + quota;
		while (tracker.polls_taken < target) begin
			kind = $urandom_range(0, 11);
			dir = $urandom_range(0, 1) ? 1 : -1;
			n = $urandom_range(0, 39) == 0 ? $urandom_range(100, 140) : $urandom_range(1, 8);
			if (kind < 8) begin
				repeat (n) turn(dir, $urandom_range(0, 19) == 0 ? PACE_EARLY : PACE_STEADY);
				// reverse, either as a bounce or around the hold time
				if (kind == 7)
					repeat ($urandom_range(1, 3))
						turn(-dir, $urandom_range(0, 1) ? PACE_HOLD : PACE_STEADY);
			end else if (kind == 8) begin
				levels = ~levels;
				next_poll(levels, PACE_STEADY);
			end else if (kind == 9) begin
				repeat ($urandom_range(1, 4)) begin
					levels = 2'($urandom);
					next_poll(levels, pace_t'($urandom_range(0, 2)));
				end
			end
			repeat ($urandom_range(0, tracker.regs.stable_polls + 2))
				next_poll(levels, $urandom_range(0, 9) == 0 ? PACE_EARLY : PACE_STEADY);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	// Hold input until every owed step is out, then let the pipeline settle.
	task automatic drain();
		push <= 1'b0;
		while (tracker.expected_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic start_phase(input logic [1:0] init);
		levels = init;
		now_us = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000000);
		now_ms = $urandom;
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		push <= 1'b0;
		poll_in <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		rx_hold_req <= 1'b0;
		rx_pattern = 16'hFFFF;
		rx_tick = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		stall_cycles = 0;
		burst_left = 0;
		levels = INIT_LEVELS_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: early polls, a step, invalid jump, bounce, late reversal, wrap
		send_poll(2'd3, 32'd0, 32'd0);
		send_poll(2'd0, 32'd4999, 32'hFFFF_FFFF);
		send_poll(2'd3, 32'd5000, 32'hFFFF_FFFF);
		send_poll(2'd1, 32'd10000, 32'd0);
		send_poll(2'd0, 32'd15000, 32'd1);
		send_poll(2'd0, 32'd20000, 32'd2);
		send_poll(2'd0, 32'd25000, 32'd3);
		send_poll(2'd3, 32'd30000, 32'd10);
		send_poll(2'd2, 32'd35000, 32'd20);
		send_poll(2'd3, 32'd40000, 32'd30);
		send_poll(2'd2, 32'd45000, 32'd40);
		send_poll(2'd0, 32'd50000, 32'd50);
		send_poll(2'd0, 32'd55000, 32'd60);
		send_poll(2'd0, 32'd60000, 32'd70);
		send_poll(2'd1, 32'd65000, 32'd500);
		send_poll(2'd0, 32'd115001, 32'd510);
		send_poll(2'd2, 32'd120000, 32'd520);
		send_poll(2'd2, 32'd125000, 32'd530);
		send_poll(2'd2, 32'd130000, 32'h7FFF_FFFF);
		send_poll(2'd2, 32'hFFFF_F000, 32'h8000_0000);
		send_poll(2'd3, 32'h0000_0387, 32'h8000_0001);
		send_poll(2'd3, 32'h0000_0388, 32'h8000_0002);
		send_poll(2'd1, 32'h0000_1710, 32'hFFFF_FFF0);
		send_poll(2'd1, 32'h0000_2A98, 32'hFFFF_FFF8);
		send_poll(2'd1, 32'h0000_3E20, 32'h0000_0005);
		levels = 2'd1;
		run_episodes(25);
		drain();

		// fast settings; the receiver holds off while the sender keeps rotating
		write_reg(REG_POLL_INTERVAL, 32'd0);
		write_reg(REG_REVERSAL_HOLD, 32'd0);
		write_reg(REG_ACC_THRESHOLD, 32'd1);
		write_reg(REG_STABLE_POLLS, 32'd1);
		write_reg(REG_ACCEL_TIMEOUT, 32'h0000_FFFF);
		write_reg(REG_MAX_ACCEL, 32'd63);
		write_reg(REG_INIT_LEVELS, 32'd0);
		cfg_valid <= 1'b0;
		start_phase(2'd0);
		rx_hold_req <= 1'b1;
		turn(1, PACE_STEADY);
		rx_hold_req <= 1'b0;
		repeat (20) turn(1, PACE_STEADY);
		run_episodes(30);
		drain();

		// widest settings, with masked-off bits set in the written data
		write_reg(REG_POLL_INTERVAL, 32'hFFFF_FFFF);
		write_reg(REG_REVERSAL_HOLD, 32'hFFFF_FFFF);
		write_reg(REG_ACC_THRESHOLD, 32'hFFFF_FF7F);
		write_reg(REG_STABLE_POLLS, 32'hFFFF_0008);
		write_reg(REG_ACCEL_TIMEOUT, 32'hFFFF_0000);
		write_reg(REG_MAX_ACCEL, 32'hFFFF_FFC1);
		write_reg(REG_INIT_LEVELS, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		start_phase(2'd3);
		// saturate the count so the top threshold is reached
		repeat (135) turn(1, PACE_STEADY);
		repeat (10) next_poll(levels, PACE_STEADY);
		run_episodes(15);
		drain();

		// zero stable polls, threshold and acceleration cap
		write_reg(REG_POLL_INTERVAL, 32'd0);
		write_reg(REG_REVERSAL_HOLD, 32'd0);
		write_reg(REG_ACC_THRESHOLD, 32'd0);
		write_reg(REG_STABLE_POLLS, 32'd0);
		write_reg(REG_ACCEL_TIMEOUT, 32'd50);
		write_reg(REG_MAX_ACCEL, 32'd0);
		write_reg(REG_INIT_LEVELS, 32'hA5A5_A5A1);
		cfg_valid <= 1'b0;
		start_phase(2'd1);
		run_episodes(30);
		drain();

		// random mid-range settings, plus a write to the unused index
		write_reg(REG_POLL_INTERVAL, {12'($urandom), 20'($urandom_range(0, 3000))});
		write_reg(REG_REVERSAL_HOLD, {12'($urandom), 20'($urandom_range(0, 20000))});
		write_reg(REG_ACC_THRESHOLD, {25'($urandom), 7'($urandom_range(1, 4))});
		write_reg(REG_STABLE_POLLS, {24'($urandom), 8'($urandom_range(1, 6))});
		write_reg(REG_ACCEL_TIMEOUT, $urandom);
		write_reg(REG_MAX_ACCEL, {26'($urandom), 6'($urandom_range(1, 63))});
		write_reg(REG_INIT_LEVELS, $urandom);
		write_reg(CFG_IDX_W'(7), $urandom);
		cfg_valid <= 1'b0;
		start_phase(tracker.regs.initial_levels);
		run_episodes(40);
		drain();

		if (tracker.failures == 0 && tracker.expected_steps.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/qea_pkg.sv
rtl/qea_front.sv
rtl/qea_evq.sv
rtl/qea_back.sv
rtl/quadrature_encoder_accel.sv
rtl/qea_checker.sv
verif/quadrature_encoder_accel_test.sv
